### rtl/s20_pkg.sv
// Shared types, constants and index tables for the Salsa20 stream cipher unit.
package s20_pkg;

    typedef logic [31:0]       t_word;
    typedef logic [15:0][31:0] t_block;

    localparam int ROUNDS_W  = 5;
    localparam int DBL_W     = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;
    localparam int POS_W     = 7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_23 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_45 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_67 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT  = 3'd6;

    localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 5'd20;

    // "expand 32-byte k" and "expand 16-byte k" diagonal constants.
    localparam t_word SIGMA_0 = 32'h61707865;
    localparam t_word SIGMA_1 = 32'h3320646e;
    localparam t_word SIGMA_2 = 32'h79622d32;
    localparam t_word SIGMA_3 = 32'h6b206574;
    localparam t_word TAU_1   = 32'h3120646e;
    localparam t_word TAU_2   = 32'h79622d36;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL
    } t_core_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_stat;

    // Word index of one role (a=0, b=1, c=2, d=3) of one quarter round.
    // half 0 is the column round, half 1 the row round.
    function automatic logic [3:0] qr_index(input logic half, input logic [1:0] lane,
                                            input logic [1:0] role);
        logic [15:0] quad;
        unique case ({half, lane})
            3'd0:    quad = {4'd12, 4'd8,  4'd4,  4'd0};
            3'd1:    quad = {4'd1,  4'd13, 4'd9,  4'd5};
            3'd2:    quad = {4'd6,  4'd2,  4'd14, 4'd10};
            3'd3:    quad = {4'd11, 4'd7,  4'd3,  4'd15};
            3'd4:    quad = {4'd3,  4'd2,  4'd1,  4'd0};
            3'd5:    quad = {4'd4,  4'd7,  4'd6,  4'd5};
            3'd6:    quad = {4'd9,  4'd8,  4'd11, 4'd10};
            default: quad = {4'd14, 4'd13, 4'd12, 4'd15};
        endcase
        return quad[{role, 2'b00} +: 4];
    endfunction

endpackage

### rtl/s20_arx.sv
// Add-rotate-xor step shared by all quarter-round updates.
module s20_arx import s20_pkg::*; (
    input  t_word      i_p,
    input  t_word      i_q,
    input  t_word      i_t,
    input  logic [1:0] i_step,
    output t_word      o_r
);

    t_word w_sum;
    t_word w_rot;

    assign w_sum = i_p + i_q;

    // The four steps of a quarter round rotate by 7, 9, 13 and 18.
    always_comb begin
        case (i_step)
            2'd0:    w_rot = {w_sum[24:0], w_sum[31:25]};
            2'd1:    w_rot = {w_sum[22:0], w_sum[31:23]};
            2'd2:    w_rot = {w_sum[18:0], w_sum[31:19]};
            default: w_rot = {w_sum[13:0], w_sum[31:14]};
        endcase
    end

    assign o_r = i_t ^ w_rot;

endmodule

### rtl/s20_core.sv
// Round sequencer: runs the double rounds on four shared ARX lanes and adds the input back.
module s20_core import s20_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_abort,
    input  logic [ROUNDS_W-1:0] i_rounds,
    input  t_block              i_in_state,
    output t_core_stat          o_stat,
    output t_block              o_block
);

    t_core_state      r_state, n_state;
    t_block           r_x, n_x;
    logic [1:0]       r_step, n_step;
    logic             r_half, n_half;
    logic [DBL_W-1:0] r_dbl, n_dbl;
    logic [DBL_W-1:0] w_dbl_req;

    t_word      w_res [4];
    logic [3:0] w_dst [4];

    assign w_dbl_req = {1'b0, i_rounds[ROUNDS_W-1:1]} + {{(DBL_W-1){1'b0}}, i_rounds[0]};

    // Each step updates one role in each of the four independent quarter rounds.
    for (genvar l = 0; l < 4; l++) begin : g_lane
        logic [3:0] w_ip, w_iq;
        assign w_ip     = qr_index(r_half, 2'(l), r_step);
        assign w_iq     = qr_index(r_half, 2'(l), r_step + 2'd3);
        assign w_dst[l] = qr_index(r_half, 2'(l), r_step + 2'd1);
        s20_arx u_arx (
            .i_p    (r_x[w_ip]),
            .i_q    (r_x[w_iq]),
            .i_t    (r_x[w_dst[l]]),
            .i_step (r_step),
            .o_r    (w_res[l])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_half  <= 1'b0;
            r_dbl   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_half  <= n_half;
            r_dbl   <= n_dbl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
    end

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_step      = r_step;
        n_half      = r_half;
        n_dbl       = r_dbl;
        o_stat.busy = (r_state != ST_IDLE);
        o_stat.done = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_x    = i_in_state;
                    n_step = 2'd0;
                    n_half = 1'b0;
                    n_dbl  = w_dbl_req;
                    n_state = (w_dbl_req == '0) ? ST_FINAL : ST_ROUND;
                end
            end
            ST_ROUND: begin
                for (int l = 0; l < 4; l++) begin
                    n_x[w_dst[l]] = w_res[l];
                end
                n_step = r_step + 2'd1;
                if (r_step == 2'd3) begin
                    n_half = ~r_half;
                    if (r_half) begin
                        n_dbl = r_dbl - 1'b1;
                        if (r_dbl == {{(DBL_W-1){1'b0}}, 1'b1}) begin
                            n_state = ST_FINAL;
                        end
                    end
                end
            end
            ST_FINAL: begin
                o_stat.done = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (i_abort) begin
            n_state = ST_IDLE;
        end
    end

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            o_block[i] = r_x[i] + i_in_state[i];
        end
    end

endmodule

### rtl/salsa20_stream_cipher_unit.sv
// Salsa20 stream cipher unit: XORs each byte with the next keystream byte.
// Latency: a byte taken on one edge appears on m_axis_tdata from the next cycle.
// Throughput: one byte per cycle within a keystream block, unless the output stalls;
// a new 64-byte block is computed on the shared ARX lanes, during which no byte is
// taken. Synchronous active-low reset clears the key, nonce and counter, sets 20
// rounds, and marks the keystream block as used up.
module salsa20_stream_cipher_unit import s20_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // Input stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] data_byte
    // Output stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata    // [7:0] result_byte
);

    // Configuration registers.
    logic [CFG_W-1:0]    r_key_01, r_key_23, r_key_45, r_key_67, r_nonce;
    logic [ROUNDS_W-1:0] r_rounds;
    logic                r_short;

    // Keystream position state. Bit 6 of the position set means the block is used up.
    logic [63:0]      r_ctr;
    logic [POS_W-1:0] r_pos;
    logic [511:0]     r_ks;

    // Output register.
    logic       r_ovalid;
    logic [7:0] r_odata;

    logic       w_cfg_hit;
    logic       w_in_fire;
    logic       w_out_free;
    logic       w_start;
    logic [CFG_W-1:0] w_k45, w_k67;
    t_block     w_in_state;
    t_block     w_block;
    t_core_stat w_stat;

    // Indexes past the register list are ignored and do not restart the stream.
    assign w_cfg_hit = i_cfg_we && (i_cfg_index <= CFG_SHORT);

    assign w_out_free    = !r_ovalid || m_axis_tready;
    assign s_axis_tready = !r_pos[POS_W-1] && !w_stat.busy && w_out_free;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;

    // A block is generated only when a byte is waiting and the current block is used up.
    assign w_start = s_axis_tvalid && r_pos[POS_W-1] && !w_stat.busy && !w_cfg_hit;

    // With a short key, key words 4 to 7 repeat words 0 to 3.
    assign w_k45 = r_short ? r_key_01 : r_key_45;
    assign w_k67 = r_short ? r_key_23 : r_key_67;

    always_comb begin
        w_in_state[0]  = SIGMA_0;
        w_in_state[1]  = r_key_01[31:0];
        w_in_state[2]  = r_key_01[63:32];
        w_in_state[3]  = r_key_23[31:0];
        w_in_state[4]  = r_key_23[63:32];
        w_in_state[5]  = r_short ? TAU_1 : SIGMA_1;
        w_in_state[6]  = r_nonce[31:0];
        w_in_state[7]  = r_nonce[63:32];
        w_in_state[8]  = r_ctr[31:0];
        w_in_state[9]  = r_ctr[63:32];
        w_in_state[10] = r_short ? TAU_2 : SIGMA_2;
        w_in_state[11] = w_k45[31:0];
        w_in_state[12] = w_k45[63:32];
        w_in_state[13] = w_k67[31:0];
        w_in_state[14] = w_k67[63:32];
        w_in_state[15] = SIGMA_3;
    end

    s20_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_abort    (w_cfg_hit),
        .i_rounds   (r_rounds),
        .i_in_state (w_in_state),
        .o_stat     (w_stat),
        .o_block    (w_block)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_01 <= '0;
            r_key_23 <= '0;
            r_key_45 <= '0;
            r_key_67 <= '0;
            r_nonce  <= '0;
            r_rounds <= ROUNDS_RESET;
            r_short  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_01: r_key_01 <= i_cfg_data;
                CFG_KEY_23: r_key_23 <= i_cfg_data;
                CFG_KEY_45: r_key_45 <= i_cfg_data;
                CFG_KEY_67: r_key_67 <= i_cfg_data;
                CFG_NONCE:  r_nonce  <= i_cfg_data;
                CFG_ROUNDS: r_rounds <= i_cfg_data[ROUNDS_W-1:0];
                CFG_SHORT:  r_short  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // A configuration write restarts the counter and discards the current block;
    // it takes priority over a block that finishes in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr <= '0;
            r_pos <= POS_W'(64);
        end else if (w_cfg_hit) begin
            r_ctr <= '0;
            r_pos <= POS_W'(64);
        end else if (w_stat.done) begin
            r_ctr <= r_ctr + 64'd1;
            r_pos <= '0;
        end else if (w_in_fire) begin
            r_pos <= r_pos + 1'b1;
        end
    end

    // The keystream block is a shift line: the next byte always sits in the low bits.
    always_ff @(posedge i_clk) begin
        if (w_stat.done) begin
            r_ks <= w_block;
        end else if (w_in_fire) begin
            r_ks <= {8'd0, r_ks[511:8]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_in_fire) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_odata <= s_axis_tdata ^ r_ks[7:0];
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule

### sim/testbench.sv
// Self-checking testbench for the Salsa20 stream cipher unit.
`timescale 1ns / 100ps

module testbench;
    import s20_pkg::*;

    // Clock period is 8 ns. The watchdog fires after this many cycles in a row
    // with no transaction on either stream.
    localparam int WATCHDOG_LIMIT = 4000;
    // The longest keystream refill is at 31 rounds. This hold-off lets any refill
    // finish before registers are rewritten.
    localparam int SETTLE_CYCLES  = 150;
    localparam int TAIL_CYCLES    = 20;
    localparam int RANDOM_ITEMS   = 600;

    // Index 7 is outside the register map. A write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    // Salsa20 diagonal constants for 256-bit ("32-byte") and 128-bit ("16-byte") keys.
    localparam t_word EXPAND_0    = 32'h61707865;
    localparam t_word EXPAND_32_1 = 32'h3320646e;
    localparam t_word EXPAND_32_2 = 32'h79622d32;
    localparam t_word EXPAND_3    = 32'h6b206574;
    localparam t_word EXPAND_16_1 = 32'h3120646e;
    localparam t_word EXPAND_16_2 = 32'h79622d36;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;   // [7:0] data_byte
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [7:0]           m_axis_tdata;   // [7:0] result_byte

    salsa20_stream_cipher_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Cipher predictor. It keeps its own copy of the registers, the block
    // counter, the read position and the current 64-byte keystream block.
    // ------------------------------------------------------------------
    logic [63:0]  key01_q, key23_q, key45_q, key67_q, nonce_q;
    logic [4:0]   rounds_q;
    logic         short_key_q;
    logic [63:0]  block_ctr_q;
    logic [6:0]   ks_pos_q;
    logic [511:0] ks_block_q;
    t_word        mix_w [16];

    // Results that were predicted but not yet seen on the output stream.
    logic [7:0]   expected_bytes [$];

    int mismatches     = 0;
    int bytes_checked  = 0;
    int blocks_made    = 0;
    int config_phases  = 0;
    int stall_cycles   = 0;
    int tx_gap_pct     = 16;
    int rx_stall_pct   = 63;

    function automatic void reset_cipher_model();
        key01_q     = '0;
        key23_q     = '0;
        key45_q     = '0;
        key67_q     = '0;
        nonce_q     = '0;
        rounds_q    = ROUNDS_RESET;
        short_key_q = 1'b0;
        block_ctr_q = '0;
        ks_pos_q    = 7'd64;
        ks_block_q  = '0;
    endfunction

    // Any write inside the register map restarts the keystream at block zero.
    // Writes outside the map are dropped without touching counter or position.
    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [63:0] val);
        case (idx)
            CFG_KEY_01: key01_q     = val;
            CFG_KEY_23: key23_q     = val;
            CFG_KEY_45: key45_q     = val;
            CFG_KEY_67: key67_q     = val;
            CFG_NONCE:  nonce_q     = val;
            CFG_ROUNDS: rounds_q    = val[4:0];
            CFG_SHORT:  short_key_q = val[0];
            default:    return;
        endcase
        block_ctr_q = '0;
        ks_pos_q    = 7'd64;
    endfunction

    function automatic t_word rotl(input t_word v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void quarter_mix(input int a, input int b, input int c, input int d);
        mix_w[b] ^= rotl(mix_w[a] + mix_w[d], 7);
        mix_w[c] ^= rotl(mix_w[b] + mix_w[a], 9);
        mix_w[d] ^= rotl(mix_w[c] + mix_w[b], 13);
        mix_w[a] ^= rotl(mix_w[d] + mix_w[c], 18);
    endfunction

    // Builds the next keystream block from the current key, nonce and counter.
    // Odd round counts round up, so the loop runs ceil(rounds / 2) double rounds.
    function automatic void refill_keystream();
        t_word       init_w [16];
        logic [63:0] k45, k67;
        t_word       sum_w;
        int          dbl;
        k45 = short_key_q ? key01_q : key45_q;
        k67 = short_key_q ? key23_q : key67_q;
        init_w[0]  = EXPAND_0;
        init_w[5]  = short_key_q ? EXPAND_16_1 : EXPAND_32_1;
        init_w[10] = short_key_q ? EXPAND_16_2 : EXPAND_32_2;
        init_w[15] = EXPAND_3;
        init_w[1]  = key01_q[31:0];
        init_w[2]  = key01_q[63:32];
        init_w[3]  = key23_q[31:0];
        init_w[4]  = key23_q[63:32];
        init_w[6]  = nonce_q[31:0];
        init_w[7]  = nonce_q[63:32];
        init_w[8]  = block_ctr_q[31:0];
        init_w[9]  = block_ctr_q[63:32];
        init_w[11] = k45[31:0];
        init_w[12] = k45[63:32];
        init_w[13] = k67[31:0];
        init_w[14] = k67[63:32];
        mix_w = init_w;
        dbl = (int'(rounds_q) + 1) / 2;
        for (int r = 0; r < dbl; r++) begin
            // Column round, then row round.
            quarter_mix(0, 4, 8, 12);
            quarter_mix(5, 9, 13, 1);
            quarter_mix(10, 14, 2, 6);
            quarter_mix(15, 3, 7, 11);
            quarter_mix(0, 1, 2, 3);
            quarter_mix(5, 6, 7, 4);
            quarter_mix(10, 11, 8, 9);
            quarter_mix(15, 12, 13, 14);
        end
        // Feed-forward; words are laid out little-endian in the byte stream.
        for (int i = 0; i < 16; i++) begin
            sum_w = mix_w[i] + init_w[i];
            ks_block_q[32*i +: 32] = sum_w;
        end
        blocks_made++;
    endfunction

    function automatic logic [7:0] next_cipher_byte(input logic [7:0] data);
        logic [7:0] ks;
        if (ks_pos_q >= 7'd64) begin
            refill_keystream();
            block_ctr_q = block_ctr_q + 64'd1;
            ks_pos_q    = '0;
        end
        ks = ks_block_q[{ks_pos_q[5:0], 3'b000} +: 8];
        ks_pos_q = ks_pos_q + 7'd1;
        return data ^ ks;
    endfunction

    function automatic void note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: mismatch: %s", $time, msg);
    endfunction

    // ------------------------------------------------------------------
    // Output side: random back-pressure, and every transaction is checked
    // against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_bytes.size() == 0) begin
                note_failure($sformatf("result_byte 0x%02h with no byte outstanding",
                                       m_axis_tdata));
            end else begin
                logic [7:0] want;
                want = expected_bytes.pop_front();
                bytes_checked++;
                if (m_axis_tdata !== want)
                    note_failure($sformatf("result_byte #%0d expected 0x%02h got 0x%02h",
                                           bytes_checked, want, m_axis_tdata));
            end
        end
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Watchdog: a hung handshake on either side ends the run.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d bytes still outstanding",
                     $time, expected_bytes.size());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Sends one byte. The valid stays high on return, so a following call can
    // keep the stream packed; the byte is predicted at the accepting edge.
    task automatic send_byte(input logic [7:0] data);
        while ($urandom_range(99) < tx_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_bytes = {expected_bytes, next_cipher_byte(data)};
    endtask

    // Stops sending and waits until every outstanding result has arrived,
    // then holds off for the given number of cycles. Nothing is assigned when
    // there is nothing to wait for, so the caller may drive valid in this step.
    task automatic wait_drained(input int hold);
        if (expected_bytes.size() != 0 || hold > 0) begin
            s_axis_tvalid <= 1'b0;
            while (expected_bytes.size() != 0) @(posedge i_clk);
            repeat (hold) @(posedge i_clk);
        end
    endtask

    // One register write; the enable is dropped for a cycle afterwards so that
    // consecutive writes never assign it twice in one step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        apply_reg_write(idx, val);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] pick_key_value();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [4:0] pick_round_count();
        case ($urandom_range(7))
            0:       return 5'd0;
            1:       return 5'd1;
            2:       return 5'd19;
            3:       return 5'd31;
            4:       return 5'($urandom_range(31));
            default: return ROUNDS_RESET;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------

    // Keystream straight out of reset: zero key and nonce, 20 rounds, long key.
    task automatic test_reset_state();
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h55);
        send_byte(8'haa);
    endtask

    // All-ones key and nonce with the round count at zero, at an odd value and
    // at its maximum. The upper bits of the round register carry junk that
    // must be ignored.
    task automatic test_round_extremes();
        wait_drained(SETTLE_CYCLES);
        config_phases++;
        write_reg(CFG_KEY_01, '1);
        write_reg(CFG_KEY_23, '1);
        write_reg(CFG_KEY_45, '1);
        write_reg(CFG_KEY_67, '1);
        write_reg(CFG_NONCE,  '1);
        write_reg(CFG_ROUNDS, 64'hffff_ffff_ffff_ffe0);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h00);

        wait_drained(SETTLE_CYCLES);
        config_phases++;
        write_reg(CFG_ROUNDS, 64'd1);
        send_byte(8'h00);
        send_byte(8'h81);
        send_byte(8'h7e);

        wait_drained(SETTLE_CYCLES);
        config_phases++;
        write_reg(CFG_ROUNDS, 64'd31);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h01);
    endtask

    // 128-bit key mode: key words 4..7 (words 4 and 5 rewritten with garbage) must not matter,
    // and the "16-byte" constants take over. Then back to the long key.
    task automatic test_short_key();
        wait_drained(SETTLE_CYCLES);
        config_phases++;
        write_reg(CFG_ROUNDS, 64'(ROUNDS_RESET));
        write_reg(CFG_KEY_01, {$urandom, $urandom});
        write_reg(CFG_KEY_23, {$urandom, $urandom});
        write_reg(CFG_KEY_45, {$urandom, $urandom});
        write_reg(CFG_SHORT,  '1);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h00);

        wait_drained(SETTLE_CYCLES);
        config_phases++;
        write_reg(CFG_SHORT, 64'hffff_ffff_ffff_fffe);
        send_byte(8'h00);
        send_byte(8'h3c);
    endtask

    // A write to an index outside the register map must leave the stream
    // position alone: the bytes after it continue the same keystream block.
    task automatic test_unused_index();
        wait_drained(SETTLE_CYCLES);
        config_phases++;
        write_reg(CFG_NONCE, {$urandom, $urandom});
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hc3);
        wait_drained(SETTLE_CYCLES);
        write_reg(CFG_UNUSED, {$urandom, $urandom});
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h00);
    endtask

    // ------------------------------------------------------------------
    // Random traffic: runs of random bytes under random settings. Most runs are
    // long enough to cross a keystream block boundary so that the counter moves.
    // The idle mix changes in thirds of the whole random test.
    // ------------------------------------------------------------------
    task automatic test_random_traffic();
        int         sent;
        int         run_len;
        logic [7:0] data;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_drained(SETTLE_CYCLES);
            config_phases++;
            if ($urandom_range(1)) write_reg(CFG_KEY_01, pick_key_value());
            if ($urandom_range(1)) write_reg(CFG_KEY_23, pick_key_value());
            if ($urandom_range(1)) write_reg(CFG_KEY_45, pick_key_value());
            if ($urandom_range(1)) write_reg(CFG_KEY_67, pick_key_value());
            if ($urandom_range(1)) write_reg(CFG_NONCE,  pick_key_value());
            if ($urandom_range(1))
                write_reg(CFG_ROUNDS, ({$urandom, $urandom} << 5) | 64'(pick_round_count()));
            if ($urandom_range(2) == 0) write_reg(CFG_SHORT, {$urandom, $urandom});
            if ($urandom_range(3) == 0) write_reg(CFG_UNUSED, {$urandom, $urandom});

            run_len = $urandom_range(3) == 0 ? $urandom_range(1, 20)
                                             : $urandom_range(60, 200);
            for (int k = 0; k < run_len && sent < RANDOM_ITEMS; k++) begin
                case (sent * 3 / RANDOM_ITEMS)
                    0:       begin tx_gap_pct = 16; rx_stall_pct = 63; end
                    1:       begin tx_gap_pct = 63; rx_stall_pct = 16; end
                    default: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
                endcase
                // Now and then the sender holds until the output has caught up.
                if ($urandom_range(39) == 0)
                    wait_drained(0);
                data = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
                send_byte(data);
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        reset_cipher_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_round_extremes();
        test_short_key();
        test_unused_index();
        test_random_traffic();

        // Drain, then hold for TAIL_CYCLES while watching for stray output transactions.
        wait_drained(TAIL_CYCLES);

        $display("Checked %0d cipher bytes over %0d register settings, %0d keystream blocks.",
                 bytes_checked, config_phases, blocks_made);
        $display("Rounds 0, odd, 20 and 31, both key sizes and an unmapped index were covered.");
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches in total", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### sim.f
rtl/s20_pkg.sv
rtl/s20_arx.sv
rtl/s20_core.sv
rtl/salsa20_stream_cipher_unit.sv
sim/testbench.sv
